### hw/rtl/inr_pkg.sv
// shared types and constants for the index node router
// no dependencies; used by every module of the block
`default_nettype none
package inr_pkg;

    // item kinds
    localparam logic [1:0] KIND_LOOKUP   = 2'd0;
    localparam logic [1:0] KIND_APPEND   = 2'd1;
    localparam logic [1:0] KIND_SORT     = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // route codes
    localparam logic [1:0] ROUTE_ENTRY    = 2'd0;
    localparam logic [1:0] ROUTE_LEFTMOST = 2'd1;
    localparam logic [1:0] ROUTE_SIBLING  = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // register indexes (byte address 4*index)
    localparam logic [2:0] REG_HIGH_KEY_VALID  = 3'd0;
    localparam logic [2:0] REG_HIGH_KEY        = 3'd1;
    localparam logic [2:0] REG_SIBLING_ID      = 3'd2;
    localparam logic [2:0] REG_LEFTMOST_ID     = 3'd3;
    localparam logic [2:0] REG_SPLIT_THRESHOLD = 3'd4;

    localparam int ADDR_W = 5;
    localparam logic [6:0] SPLIT_THRESHOLD_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] key;
        logic [31:0]        child_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        child_out;
        logic [1:0]         route;
        logic [1:0]         status;
        logic [6:0]         entry_count;
        logic               split_needed;
        logic signed [31:0] split_key;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        child;
    } entry_t;

    typedef struct packed {
        logic lt0;
        logic lt1;
    } cmp_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_LFIRST,
        ST_LSCAN,
        ST_SI,
        ST_SJ,
        ST_SPUT,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/inr_mem.sv
// pair table memory: one write port, one read port with registered data
// depends on inr_pkg for the entry type
`default_nettype none
module inr_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire inr_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output inr_pkg::entry_t      rdata
);

    inr_pkg::entry_t mem [DEPTH];
    inr_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### hw/rtl/inr_cmp.sv
// shared signed key compare unit, two less-than lanes
// depends on inr_pkg for the result struct
`default_nettype none
module inr_cmp (
    input  wire logic signed [31:0] a0,
    input  wire logic signed [31:0] b0,
    input  wire logic signed [31:0] a1,
    input  wire logic signed [31:0] b1,
    output inr_pkg::cmp_res_t       res
);

    assign res.lt0 = (a0 < b0);
    assign res.lt1 = (a1 < b1);

endmodule
`default_nettype wire

### hw/rtl/index_node_router.sv
// index node router top level: sequencer, registers, output stage
// depends on inr_pkg, inr_mem, inr_cmp
//
// usage
//   input channel in_valid / in_stall / in_item carries one item: lookup,
//   append or sort. output channel out_valid / out_stall / out_item carries
//   exactly one result item per input item, in order.
//   the user must write registers over the apb port only while the block is idle; the block itself does not enforce it.
// sequencing
//   one item at a time; in_stall is high from acceptance until the result
//   is moved into the output register.
//   append or unused kind: dispatch, middle entry fetch, output. lookup: one
//   table read per entry through the single memory read port.
//   sort: insertion sort, one read per compare step; the shared compare
//   unit and the single read port set the pace.
// reset
//   rst_n clears the count, the registers and the handshake state; the
//   table is not cleared, entries at or above count are never used.
// stall
//   a stalled result stays in the output register; the next item is still
//   accepted and runs, and its result waits until the register frees.
`default_nettype none
module index_node_router #(
    parameter int CAPACITY = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire inr_pkg::in_item_t              in_item,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output inr_pkg::out_item_t                  out_item,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [inr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    // configuration registers
    logic               hk_valid_reg;
    logic signed [31:0] high_key_reg;
    logic [31:0]        sibling_reg;
    logic [31:0]        leftmost_reg;
    logic [6:0]         thr_reg;

    // sequencer state
    inr_pkg::state_t    state_reg, state_next;
    logic [1:0]         kind_reg, kind_next;
    logic signed [31:0] key_reg, key_next;
    logic [31:0]        cin_reg, cin_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    inr_pkg::entry_t    cur_reg, cur_next;     // lookup best entry, or sort key in hand
    logic [31:0]        rchild_reg, rchild_next;
    logic [1:0]         rroute_reg, rroute_next;
    logic [1:0]         rstatus_reg, rstatus_next;

    // output stage
    logic               out_valid_reg, out_valid_next;
    inr_pkg::out_item_t out_item_reg, out_item_next;

    // memory and compare unit
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    inr_pkg::entry_t    mem_wdata, mem_rdata;
    logic signed [31:0] ca0, cb0, ca1, cb1;
    inr_pkg::cmp_res_t  cmp;

    logic               cfg_wr;
    logic [CW-1:0]      i_inc;
    logic [CMPW-1:0]    count_ext;

    inr_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    inr_cmp u_cmp (
        .a0  (ca0),
        .b0  (cb0),
        .a1  (ca1),
        .b1  (cb1),
        .res (cmp)
    );

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hk_valid_reg <= 1'b0;
            high_key_reg <= '0;
            sibling_reg  <= '0;
            leftmost_reg <= '0;
            thr_reg      <= inr_pkg::SPLIT_THRESHOLD_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                inr_pkg::REG_HIGH_KEY_VALID:  hk_valid_reg <= pwdata[0];
                inr_pkg::REG_HIGH_KEY:        high_key_reg <= pwdata;
                inr_pkg::REG_SIBLING_ID:      sibling_reg  <= pwdata;
                inr_pkg::REG_LEFTMOST_ID:     leftmost_reg <= pwdata;
                inr_pkg::REG_SPLIT_THRESHOLD: thr_reg      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            inr_pkg::REG_HIGH_KEY_VALID:  prdata = {31'd0, hk_valid_reg};
            inr_pkg::REG_HIGH_KEY:        prdata = high_key_reg;
            inr_pkg::REG_SIBLING_ID:      prdata = sibling_reg;
            inr_pkg::REG_LEFTMOST_ID:     prdata = leftmost_reg;
            inr_pkg::REG_SPLIT_THRESHOLD: prdata = {25'd0, thr_reg};
            default:                      prdata = '0;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= inr_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        cin_reg      <= cin_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cur_reg      <= cur_next;
        rchild_reg   <= rchild_next;
        rroute_reg   <= rroute_next;
        rstatus_reg  <= rstatus_next;
        out_item_reg <= out_item_next;
    end

    assign i_inc     = i_reg + CW'(1);
    assign count_ext = CMPW'(count_reg);
    assign in_stall  = (state_reg != inr_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // next state, memory control and compare operands
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        cin_next       = cin_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        rchild_next    = rchild_reg;
        rroute_next    = rroute_reg;
        rstatus_next   = rstatus_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = cur_reg;
        mem_re    = 1'b0;
        mem_raddr = '0;

        ca0 = key_reg;
        cb0 = mem_rdata.key;
        ca1 = mem_rdata.key;
        cb1 = cur_reg.key;

        case (state_reg)
            inr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next    = in_item.kind;
                    key_next     = in_item.key;
                    cin_next     = in_item.child_in;
                    rchild_next  = '0;
                    rroute_next  = inr_pkg::ROUTE_ENTRY;
                    rstatus_next = inr_pkg::STATUS_DONE;
                    state_next   = inr_pkg::ST_DISP;
                end
            end

            inr_pkg::ST_DISP:
            begin
                cb0 = high_key_reg;
                case (kind_reg)
                    inr_pkg::KIND_LOOKUP:
                    begin
                        if (count_reg == '0)
                        begin
                            rstatus_next = inr_pkg::STATUS_EMPTY;
                            state_next   = inr_pkg::ST_FIN;
                        end
                        else if (hk_valid_reg && !cmp.lt0)
                        begin
                            rchild_next = sibling_reg;
                            rroute_next = inr_pkg::ROUTE_SIBLING;
                            state_next  = inr_pkg::ST_FIN;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = inr_pkg::ST_LFIRST;
                        end
                    end
                    inr_pkg::KIND_APPEND:
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            rstatus_next = inr_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(count_reg);
                            mem_wdata  = '{key: key_reg, child: cin_reg};
                            count_next = count_reg + CW'(1);
                        end
                        state_next = inr_pkg::ST_FIN;
                    end
                    inr_pkg::KIND_SORT:
                    begin
                        if (count_reg > CW'(1))
                        begin
                            i_next     = CW'(1);
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(1);
                            state_next = inr_pkg::ST_SI;
                        end
                        else
                        begin
                            state_next = inr_pkg::ST_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = inr_pkg::ST_FIN;
                    end
                endcase
            end

            // entry 0 on the read port
            inr_pkg::ST_LFIRST:
            begin
                if (cmp.lt0)
                begin
                    rchild_next = leftmost_reg;
                    rroute_next = inr_pkg::ROUTE_LEFTMOST;
                    state_next  = inr_pkg::ST_FIN;
                end
                else
                begin
                    cur_next    = mem_rdata;
                    rchild_next = mem_rdata.child;
                    i_next      = CW'(1);
                    if (count_reg > CW'(1))
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(1);
                        state_next = inr_pkg::ST_LSCAN;
                    end
                    else
                    begin
                        state_next = inr_pkg::ST_FIN;
                    end
                end
            end

            // entry i on the read port; keep it if best <= key_i <= key
            inr_pkg::ST_LSCAN:
            begin
                if (!cmp.lt0 && !cmp.lt1)
                begin
                    cur_next    = mem_rdata;
                    rchild_next = mem_rdata.child;
                end
                i_next = i_inc;
                if (i_inc < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(i_inc);
                end
                else
                begin
                    state_next = inr_pkg::ST_FIN;
                end
            end

            // entry i in hand, fetch its left neighbor
            inr_pkg::ST_SI:
            begin
                cur_next   = mem_rdata;
                j_next     = i_reg;
                mem_re     = 1'b1;
                mem_raddr  = AW'(i_reg - CW'(1));
                state_next = inr_pkg::ST_SJ;
            end

            // entry j-1 on the read port; shift right while larger
            inr_pkg::ST_SJ:
            begin
                ca0 = cur_reg.key;
                if (cmp.lt0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(j_reg);
                    mem_wdata = mem_rdata;
                    j_next    = j_reg - CW'(1);
                    if (j_reg == CW'(1))
                    begin
                        state_next = inr_pkg::ST_SPUT;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(j_reg - CW'(2));
                    end
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(j_reg);
                    i_next    = i_inc;
                    if (i_inc < count_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(i_inc);
                        state_next = inr_pkg::ST_SI;
                    end
                    else
                    begin
                        state_next = inr_pkg::ST_FIN;
                    end
                end
            end

            // held entry goes to the front
            inr_pkg::ST_SPUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                i_next    = i_inc;
                if (i_inc < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(i_inc);
                    state_next = inr_pkg::ST_SI;
                end
                else
                begin
                    state_next = inr_pkg::ST_FIN;
                end
            end

            // fetch the middle entry for the split key
            inr_pkg::ST_FIN:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(count_reg >> 1);
                state_next = inr_pkg::ST_OUT;
            end

            inr_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.child_out    = rchild_reg;
                    out_item_next.route        = rroute_reg;
                    out_item_next.status       = rstatus_reg;
                    out_item_next.entry_count  = count_ext[6:0];
                    out_item_next.split_needed = (count_ext >= CMPW'(thr_reg));
                    out_item_next.split_key    = (count_reg == '0) ? '0 : mem_rdata.key;
                    state_next                 = inr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = inr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/inr_checker.sv
// port-level checks for the index node router, bound to the top level
// depends on inr_pkg and index_node_router
`default_nettype none
module inr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire inr_pkg::out_item_t out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // a sibling or leftmost route comes only with done status
    a_route: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.route != inr_pkg::ROUTE_ENTRY
            |-> out_item.status == inr_pkg::STATUS_DONE)
        else $error("route with non-done status");

    // an empty node reports a zero split key
    a_split_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.entry_count == 7'd0 |-> out_item.split_key == 32'sd0)
        else $error("split key nonzero on empty node");

endmodule

bind index_node_router inr_checker u_inr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
`default_nettype wire

### tb/index_node_router_tb.sv
// testbench for the index node router: directed table then random items
// depends on inr_pkg and index_node_router; checks every result against a local node model
`timescale 1ns / 1ps
`default_nettype none
module index_node_router_tb;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 5000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    inr_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    inr_pkg::out_item_t out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [inr_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    index_node_router #(.CAPACITY(CAP)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // node model state, mirrors what the block should hold
    logic               nd_hk_valid;
    logic signed [31:0] nd_high_key;
    logic [31:0]        nd_sibling;
    logic [31:0]        nd_leftmost;
    logic [6:0]         nd_threshold;
    logic signed [31:0] nd_keys [CAP];
    logic [31:0]        nd_childs [CAP];
    int                 nd_count;

    inr_pkg::out_item_t pending_results[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  long_stalls = 1'b1;

    // advance the node model by one item and return its result
    function automatic inr_pkg::out_item_t node_advance(inr_pkg::in_item_t it);
        inr_pkg::out_item_t r;
        int i, j, best;
        logic signed [31:0] k;
        logic [31:0] c;
        r = '0;
        if (it.kind == inr_pkg::KIND_LOOKUP) begin
            if (nd_count == 0)
                r.status = inr_pkg::STATUS_EMPTY;
            else if (nd_hk_valid && it.key >= nd_high_key) begin
                r.child_out = nd_sibling;
                r.route = inr_pkg::ROUTE_SIBLING;
            end
            else if (it.key < nd_keys[0]) begin
                r.child_out = nd_leftmost;
                r.route = inr_pkg::ROUTE_LEFTMOST;
            end
            else begin
                // largest key <= search key, ties to highest index
                best = 0;
                for (i = 1; i < nd_count; i++)
                    if (nd_keys[i] <= it.key && nd_keys[i] >= nd_keys[best])
                        best = i;
                r.child_out = nd_childs[best];
                r.route = inr_pkg::ROUTE_ENTRY;
            end
        end
        else if (it.kind == inr_pkg::KIND_APPEND) begin
            if (nd_count >= CAP)
                r.status = inr_pkg::STATUS_FULL;
            else begin
                nd_keys[nd_count] = it.key;
                nd_childs[nd_count] = it.child_in;
                nd_count++;
            end
        end
        else if (it.kind == inr_pkg::KIND_SORT) begin
            // stable insertion sort
            for (i = 1; i < nd_count; i++) begin
                k = nd_keys[i];
                c = nd_childs[i];
                j = i;
                while (j > 0 && nd_keys[j-1] > k) begin
                    nd_keys[j] = nd_keys[j-1];
                    nd_childs[j] = nd_childs[j-1];
                    j--;
                end
                nd_keys[j] = k;
                nd_childs[j] = c;
            end
        end
        r.entry_count = nd_count[6:0];
        r.split_needed = (nd_count >= nd_threshold);
        r.split_key = (nd_count > 0) ? nd_keys[nd_count / 2] : '0;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // register write over the apb port, with the model updated alongside
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = inr_pkg::ADDR_W'({idx, 2'b00});
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            inr_pkg::REG_HIGH_KEY_VALID:  nd_hk_valid = val[0];
            inr_pkg::REG_HIGH_KEY:        nd_high_key = val;
            inr_pkg::REG_SIBLING_ID:      nd_sibling = val;
            inr_pkg::REG_LEFTMOST_ID:     nd_leftmost = val;
            inr_pkg::REG_SPLIT_THRESHOLD: nd_threshold = val[6:0];
            default: ;
        endcase
    endtask

    // present one item, wait for acceptance; the model runs on acceptance
    task automatic send_item(input inr_pkg::in_item_t it, input bit has_fixed,
                             input inr_pkg::out_item_t fixed);
        inr_pkg::out_item_t r;
        int g;
        g = gap_len();
        repeat (g) @(negedge clk);
        in_item = it;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        r = node_advance(it);
        if (has_fixed && r != fixed) begin
            $error("directed row mismatch exp %h model %h", fixed, r);
            fail_count++;
        end
        pending_results.push_back(r);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // wait until every expected result has come, plus a quiet margin
    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // output side: random stalls, field checks against the oldest expectation
    always @(negedge clk) begin
        if (!long_stalls)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= (gap_len() != 0);
    end

    always @(posedge clk) begin
        inr_pkg::out_item_t e;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation: %h", out_item);
                fail_count++;
            end
            else begin
                e = pending_results.pop_front();
                if (out_item.child_out !== e.child_out) begin
                    $error("child_out exp %h got %h", e.child_out, out_item.child_out);
                    fail_count++;
                end
                if (out_item.route !== e.route) begin
                    $error("route exp %0d got %0d", e.route, out_item.route);
                    fail_count++;
                end
                if (out_item.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, out_item.status);
                    fail_count++;
                end
                if (out_item.entry_count !== e.entry_count) begin
                    $error("entry_count exp %0d got %0d", e.entry_count,
                           out_item.entry_count);
                    fail_count++;
                end
                if (out_item.split_needed !== e.split_needed) begin
                    $error("split_needed exp %0d got %0d", e.split_needed,
                           out_item.split_needed);
                    fail_count++;
                end
                if (out_item.split_key !== e.split_key) begin
                    $error("split_key exp %h got %h", e.split_key, out_item.split_key);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic inr_pkg::out_item_t mk_res(logic [31:0] co, logic [1:0] rt,
                                                  logic [1:0] st, logic [6:0] cnt,
                                                  logic sn, logic [31:0] sk);
        inr_pkg::out_item_t r;
        r.child_out = co;
        r.route = rt;
        r.status = st;
        r.entry_count = cnt;
        r.split_needed = sn;
        r.split_key = sk;
        return r;
    endfunction

    // directed table: item plus optional typed-in result
    typedef struct {
        inr_pkg::in_item_t  it;
        bit                 has_fixed;
        inr_pkg::out_item_t res;
    } dir_row_t;

    // random key, from a small pool when pool is set so lookups hit ties and exact matches
    function automatic logic [31:0] rand_key(bit pool);
        int p;
        if (pool) return 32'($signed($urandom_range(0, 15)) - 8) * 1000;
        p = $urandom_range(0, 9);
        if (p == 0) return 32'h8000_0000;
        if (p == 1) return 32'h7fff_ffff;
        return $urandom;
    endfunction

    initial begin
        dir_row_t rows[$];
        dir_row_t row;
        inr_pkg::in_item_t it;
        int n, phase, burst, fill;
        bit pool;

        nd_hk_valid = 1'b0;
        nd_high_key = '0;
        nd_sibling = '0;
        nd_leftmost = '0;
        nd_threshold = inr_pkg::SPLIT_THRESHOLD_RESET;
        nd_count = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // lookup, unused kind and sort on an empty node
        row.it = '{inr_pkg::KIND_LOOKUP, 32'sh7fff_ffff, 32'hffff_ffff};
        row.has_fixed = 1'b1;
        row.res = mk_res('0, inr_pkg::ROUTE_ENTRY, inr_pkg::STATUS_EMPTY, 7'd0, 1'b0, '0);
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_RESERVED, 32'sh8000_0000, 32'h0};
        row.res = mk_res('0, inr_pkg::ROUTE_ENTRY, inr_pkg::STATUS_DONE, 7'd0, 1'b0, '0);
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_SORT, 32'sh0, 32'h0};
        rows.push_back(row);
        // first append: count 1, middle key is the appended key
        row.it = '{inr_pkg::KIND_APPEND, 32'sh7fff_ffff, 32'hffff_ffff};
        row.res = mk_res('0, inr_pkg::ROUTE_ENTRY, inr_pkg::STATUS_DONE, 7'd1, 1'b0,
                         32'h7fff_ffff);
        rows.push_back(row);
        row.has_fixed = 1'b0;
        row.it = '{inr_pkg::KIND_APPEND, 32'sh8000_0000, 32'h0};
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_APPEND, 32'sh0, 32'h1234_5678};
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_APPEND, 32'sh0, 32'h8765_4321};
        rows.push_back(row);
        // lookups on the unsorted table: tie, exact, extremes
        row.it = '{inr_pkg::KIND_LOOKUP, 32'sh0, 32'h0};
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_LOOKUP, 32'sh8000_0000, 32'h0};
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_LOOKUP, 32'sh7fff_ffff, 32'h0};
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_LOOKUP, -32'sd1, 32'h0};
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_SORT, 32'sh0, 32'h0};
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_LOOKUP, 32'sh7fff_fffe, 32'h0};
        rows.push_back(row);
        row.it = '{inr_pkg::KIND_LOOKUP, 32'sh1, 32'h0};
        rows.push_back(row);

        foreach (rows[i])
            send_item(rows[i].it, rows[i].has_fixed, rows[i].res);
        drain();

        // register extremes: high key set at 0, threshold low
        reg_write(inr_pkg::REG_HIGH_KEY_VALID, 32'h1);
        reg_write(inr_pkg::REG_HIGH_KEY, 32'h0);
        reg_write(inr_pkg::REG_SIBLING_ID, 32'hffff_ffff);
        reg_write(inr_pkg::REG_LEFTMOST_ID, 32'hffff_ffff);
        reg_write(inr_pkg::REG_SPLIT_THRESHOLD, 32'h1);
        // leftmost cannot be hit since min key is stored; sibling at key 0
        send_item('{inr_pkg::KIND_LOOKUP, 32'sh0, 32'h0}, 1'b1,
                  mk_res(32'hffff_ffff, inr_pkg::ROUTE_SIBLING, inr_pkg::STATUS_DONE,
                         7'd4, 1'b1, 32'h0));
        send_item('{inr_pkg::KIND_LOOKUP, -32'sd1, 32'h0}, 1'b0, '0);
        // fill to capacity, then one dropped append
        while (nd_count < CAP)
            send_item('{inr_pkg::KIND_APPEND, 32'($urandom), 32'($urandom)}, 1'b0, '0);
        send_item('{inr_pkg::KIND_APPEND, 32'sh5, 32'h5}, 1'b0, '0);
        send_item('{inr_pkg::KIND_SORT, 32'sh0, 32'h0}, 1'b0, '0);
        send_item('{inr_pkg::KIND_LOOKUP, 32'sh8000_0000, 32'h0}, 1'b0, '0);
        send_item('{inr_pkg::KIND_LOOKUP, 32'($urandom), 32'h0}, 1'b0, '0);
        drain();

        // random phases on the full node: registers vary per phase, lookups,
        // sorts, dropped appends and unused kinds are mixed in each burst
        n = 0;
        phase = 0;
        while (n < 420) begin
            case (phase % 4)
                0: begin
                    reg_write(inr_pkg::REG_HIGH_KEY_VALID, 32'h0);
                    reg_write(inr_pkg::REG_SPLIT_THRESHOLD, 32'h0);
                    reg_write(inr_pkg::REG_LEFTMOST_ID, $urandom);
                end
                1: begin
                    reg_write(inr_pkg::REG_HIGH_KEY_VALID, 32'h1);
                    reg_write(inr_pkg::REG_HIGH_KEY, 32'h7fff_ffff);
                    reg_write(inr_pkg::REG_SIBLING_ID, $urandom);
                    reg_write(inr_pkg::REG_SPLIT_THRESHOLD, 32'd64);
                end
                2: begin
                    reg_write(inr_pkg::REG_HIGH_KEY, 32'h8000_0000);
                    reg_write(inr_pkg::REG_SPLIT_THRESHOLD, 32'h7f);
                end
                default: begin
                    reg_write(inr_pkg::REG_HIGH_KEY_VALID, 32'($urandom_range(0, 1)));
                    reg_write(inr_pkg::REG_HIGH_KEY, $urandom);
                    reg_write(inr_pkg::REG_SPLIT_THRESHOLD, 32'($urandom_range(0, 127)));
                end
            endcase
            long_stalls = phase[0];
            burst = $urandom_range(40, 80);
            pool = phase[1];
            repeat (burst) begin
                it.key = rand_key(pool);
                it.child_in = $urandom;
                fill = $urandom_range(0, 99);
                if (fill < 70) it.kind = inr_pkg::KIND_LOOKUP;
                else if (fill < 85) it.kind = inr_pkg::KIND_APPEND;
                else if (fill < 95) it.kind = inr_pkg::KIND_SORT;
                else it.kind = inr_pkg::KIND_RESERVED;
                send_item(it, 1'b0, '0);
                n++;
            end
            drain();
            phase++;
        end

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
hw/rtl/inr_pkg.sv
hw/rtl/inr_mem.sv
hw/rtl/inr_cmp.sv
hw/rtl/index_node_router.sv
hw/rtl/inr_checker.sv
tb/index_node_router_tb.sv
